>>> hdl/tlbr_pkg.sv
// ----------------------------------------------------------------------------
// tlbr_pkg
// Shared types and constants for the fully associative TLB with FIFO/LRU
// replacement: payload structs, opcodes, register map, controller interface.
// ----------------------------------------------------------------------------
package tlbr_pkg;

  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 20;
  localparam int STAMP_BITS = 32;
  localparam int EIU_BITS   = 5;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  localparam logic                POLICY_RST  = 1'b0;
  localparam logic [EIU_BITS-1:0] ENTRIES_RST = 5'd16;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [PAGE_BITS-1:0]  page_number;
    logic [FRAME_BITS-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_VICTIM,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic exec;          // item transfer: lookup, flush or insert into a free entry
    logic scan_issue;    // issue next stamp read of the victim scan
    logic victim_write;  // write the pending insert over the chosen victim
    logic respond;       // load the output register and advance the tick
  } ctrl_cmd_t;

  typedef struct packed {
    logic insert_full;   // incoming item is an insert with no free entry
    logic scan_last;     // scan address is at the last active entry
    logic out_free;      // output register can take a result this cycle
  } dp_status_t;

endpackage

>>> hdl/tlbr_ram.sv
// ----------------------------------------------------------------------------
// tlbr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tlbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tlbr_ctrl.sv
// ----------------------------------------------------------------------------
// tlbr_ctrl
// Controller: sequences each item through execute, optional victim scan,
// victim write and response.
// ----------------------------------------------------------------------------
module tlbr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  tlbr_pkg::dp_status_t st_i,
  output logic                 in_ready_o,
  output tlbr_pkg::ctrl_cmd_t  cmd_o
);
  import tlbr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = st_i.insert_full ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (st_i.scan_last) begin
          state_d = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_d = ST_VICTIM;
      ST_VICTIM:    state_d = ST_RESP;
      ST_RESP: begin
        if (st_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = (state_q == ST_IDLE);
    cmd_o.exec         = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan_issue   = (state_q == ST_SCAN);
    cmd_o.victim_write = (state_q == ST_VICTIM);
    cmd_o.respond      = (state_q == ST_RESP) && st_i.out_free;
  end

endmodule

>>> hdl/tlbr_dp.sv
// ----------------------------------------------------------------------------
// tlbr_dp
// Datapath: valid bits and page tags in flops with a parallel compare, frame
// and stamp RAMs, the victim age search, tick counter and output register.
// ----------------------------------------------------------------------------
module tlbr_dp #(
  parameter int ENTRIES = 16,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tlbr_pkg::ctrl_cmd_t               cmd_i,
  input  tlbr_pkg::in_item_t                in_data_i,
  input  logic                              policy_i,
  input  logic [tlbr_pkg::EIU_BITS-1:0]     eiu_i,
  input  logic                              out_ready_i,
  output tlbr_pkg::dp_status_t              st_o,
  output logic                              out_valid_o,
  output tlbr_pkg::out_item_t               out_data_o
);
  import tlbr_pkg::*;

  logic [ENTRIES-1:0]   valid_q;
  logic [PAGE_BITS-1:0] page_q [ENTRIES];
  logic [STAMP_BITS-1:0] tick_q;

  logic [PAGE_BITS-1:0]  item_page_q;
  logic [FRAME_BITS-1:0] item_frame_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;

  logic [IDX_W-1:0]      scan_addr_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  logic [STAMP_BITS-1:0] best_age_q;
  logic [IDX_W-1:0]      best_idx_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  // active entries: index 0 .. last_idx
  logic [IDX_W-1:0] last_idx;
  always_comb begin
    if (eiu_i == '0) begin
      last_idx = '0;
    end else if (int'(eiu_i) >= ENTRIES) begin
      last_idx = IDX_W'(ENTRIES - 1);
    end else begin
      last_idx = IDX_W'(eiu_i - EIU_BITS'(1));
    end
  end

  logic [ENTRIES-1:0] match_vec, free_vec;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      logic in_use;
      in_use       = (IDX_W'(i) <= last_idx);
      match_vec[i] = valid_q[i] && in_use && (page_q[i] == in_data_i.page_number);
      free_vec[i]  = !valid_q[i] && in_use;
    end
  end

  // lowest set index wins
  logic [IDX_W-1:0] match_idx, free_idx;
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IDX_W'(i);
      if (free_vec[i])  free_idx  = IDX_W'(i);
    end
  end

  logic is_lookup, is_insert, is_flush, any_match, any_free;
  assign is_lookup = (in_data_i.opcode == OP_LOOKUP);
  assign is_insert = (in_data_i.opcode == OP_INSERT);
  assign is_flush  = (in_data_i.opcode == OP_FLUSH);
  assign any_match = |match_vec;
  assign any_free  = |free_vec;

  // entry fill: free entry at transfer, or victim after the scan
  logic                  fill_we;
  logic [IDX_W-1:0]      fill_idx;
  logic [PAGE_BITS-1:0]  fill_page;
  logic [FRAME_BITS-1:0] fill_frame;
  logic                  touch_we;
  assign fill_we    = (cmd_i.exec && is_insert && any_free) || cmd_i.victim_write;
  assign fill_idx   = cmd_i.victim_write ? best_idx_q : free_idx;
  assign fill_page  = cmd_i.victim_write ? item_page_q : in_data_i.page_number;
  assign fill_frame = cmd_i.victim_write ? item_frame_q : in_data_i.frame_number;
  assign touch_we   = cmd_i.exec && is_lookup && any_match && policy_i;

  logic [FRAME_BITS-1:0] frame_rd;
  logic [STAMP_BITS-1:0] load_rd, use_rd;
  logic [IDX_W-1:0]      frame_raddr;
  assign frame_raddr = cmd_i.exec ? match_idx : hit_idx_q;

  tlbr_ram #(.WIDTH(FRAME_BITS), .DEPTH(ENTRIES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_idx),
    .wdata_i (fill_frame),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rd)
  );

  tlbr_ram #(.WIDTH(STAMP_BITS), .DEPTH(ENTRIES)) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_idx),
    .wdata_i (tick_q),
    .raddr_i (scan_addr_q),
    .rdata_o (load_rd)
  );

  tlbr_ram #(.WIDTH(STAMP_BITS), .DEPTH(ENTRIES)) u_use_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we || touch_we),
    .waddr_i (touch_we ? match_idx : fill_idx),
    .wdata_i (tick_q),
    .raddr_i (scan_addr_q),
    .rdata_o (use_rd)
  );

  // victim search: age = tick - stamp, largest age wins, ties to lowest index
  logic [STAMP_BITS-1:0] scan_age;
  logic                  take_best;
  assign scan_age  = tick_q - (policy_i ? use_rd : load_rd);
  assign take_best = cmp_vld_q && ((cmp_idx_q == '0) || (scan_age > best_age_q));

  logic out_valid_d;
  assign out_valid_d = cmd_i.respond ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      tick_q      <= '0;
      hit_q       <= 1'b0;
      cmp_vld_q   <= 1'b0;
      scan_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec && is_flush) begin
        valid_q <= '0;
      end else if (fill_we) begin
        valid_q[fill_idx] <= 1'b1;
      end
      if (cmd_i.exec) begin
        hit_q       <= is_lookup && any_match;
        scan_addr_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
      end
      cmp_vld_q <= cmd_i.scan_issue;
      if (cmd_i.respond) begin
        tick_q <= tick_q + STAMP_BITS'(1);
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fill_we && (fill_idx == IDX_W'(i))) begin
        page_q[i] <= fill_page;
      end
    end
    if (cmd_i.exec) begin
      item_page_q  <= in_data_i.page_number;
      item_frame_q <= in_data_i.frame_number;
      hit_idx_q    <= match_idx;
    end
    cmp_idx_q <= scan_addr_q;
    if (take_best) begin
      best_age_q <= scan_age;
      best_idx_q <= cmp_idx_q;
    end
    if (cmd_i.respond) begin
      out_data_q.hit       <= hit_q;
      out_data_q.frame_out <= hit_q ? frame_rd : '0;
    end
  end

  assign st_o.insert_full = is_insert && !any_free;
  assign st_o.scan_last   = (scan_addr_q == last_idx);
  assign st_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;

endmodule

>>> hdl/tlb_fifo_lru_replacement.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replacement
// Fully associative TLB: lookup, insert and flush with FIFO or LRU victim
// choice, configured through an APB-style register port.
// ----------------------------------------------------------------------------
// Lookup, flush and insert into a free entry: executed at transfer with a
//   parallel tag compare, result registered in the response state.
// Insert with every active entry valid: the stamp scan reads the n active
//   entries one by one through one read port of the stamp RAMs, then the victim
//   is written and the result registered. One item in flight at a time.
// Reset clears valid bits and the tick counter at once, selects FIFO and
//   16 active entries; there is no clearing pass.
module tlb_fifo_lru_replacement #(
  parameter int ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tlbr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tlbr_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tlbr_pkg::*;

  logic                policy_q;
  logic [EIU_BITS-1:0] eiu_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RST;
      eiu_q    <= ENTRIES_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_POLICY:  policy_q <= pwdata[0];
        REG_ENTRIES: eiu_q    <= pwdata[EIU_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POLICY:  prdata = {31'b0, policy_q};
      REG_ENTRIES: prdata = {{(32-EIU_BITS){1'b0}}, eiu_q};
      default:     prdata = '0;
    endcase
  end

  ctrl_cmd_t  cmd;
  dp_status_t st;

  tlbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  tlbr_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .policy_i    (policy_q),
    .eiu_i       (eiu_q),
    .out_ready_i (out_ready_i),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // one item in flight: no transfer right after a transfer
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input transfer accepted while item in flight");

  // a new result only comes from the response state, never from idle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result produced without an item in flight");

  // victim write only follows a completed scan
  a_victim_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.victim_write |-> $past(cmd.scan_issue, 2))
    else $error("victim written without a scan");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tlb_fifo_lru_replacement. A cycle-free TLB model
// predicts hit/frame per item. Directed lookups, inserts, duplicates, flush,
// FIFO and LRU victims come first, then random traffic over several register
// settings with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tlbr_pkg::*;

  localparam int         ENTRIES      = 16;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic       POL_FIFO     = 1'b0;
  localparam logic       POL_LRU      = 1'b1;
  // leave margin for the longest victim scan after the last result
  localparam int         DRAIN_CYCLES = 2 * ENTRIES + 16;
  localparam int         STALL_LIMIT  = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tlb_fifo_lru_replacement #(.ENTRIES(ENTRIES)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- TLB model
  logic                  ent_valid  [ENTRIES];
  logic [PAGE_BITS-1:0]  ent_page   [ENTRIES];
  logic [FRAME_BITS-1:0] ent_frame  [ENTRIES];
  logic [STAMP_BITS-1:0] ent_loaded [ENTRIES];
  logic [STAMP_BITS-1:0] ent_used   [ENTRIES];
  logic [STAMP_BITS-1:0] tick;
  logic                  cfg_lru;
  logic [EIU_BITS-1:0]   cfg_entries;

  out_item_t expected_xlat [$];
  int        mismatch_cnt = 0;
  int        idle_cycles  = 0;
  bit        in_calm      = 1'b0;
  bit        out_calm     = 1'b0;

  function automatic int active_entries();
    if (cfg_entries == 0) return 1;
    if (cfg_entries > ENTRIES) return ENTRIES;
    return int'(cfg_entries);
  endfunction

  function automatic void clear_tlb_model();
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i]  = 1'b0;
      ent_page[i]   = '0;
      ent_frame[i]  = '0;
      ent_loaded[i] = '0;
      ent_used[i]   = '0;
    end
  endfunction

  // free entry first, else the oldest stamp (wrapping age), lowest index on ties
  function automatic int victim_slot();
    int                    n = active_entries();
    int                    best = 0;
    int                    free_slot = -1;
    logic [STAMP_BITS-1:0] best_age = '0;
    logic [STAMP_BITS-1:0] age;
    for (int i = n - 1; i >= 0; i--)
      if (!ent_valid[i]) free_slot = i;
    if (free_slot >= 0) return free_slot;
    for (int i = 0; i < n; i++) begin
      age = tick - (cfg_lru ? ent_used[i] : ent_loaded[i]);
      if (i == 0 || age > best_age) begin
        best_age = age;
        best     = i;
      end
    end
    return best;
  endfunction

  function automatic out_item_t translate_item(in_item_t it);
    out_item_t r;
    int        n = active_entries();
    int        s;
    bit        found = 1'b0;
    r = '0;
    case (it.opcode)
      OP_LOOKUP: begin
        for (int i = 0; i < n; i++) begin
          if (!found && ent_valid[i] && ent_page[i] == it.page_number) begin
            found       = 1'b1;
            r.hit       = 1'b1;
            r.frame_out = ent_frame[i];
            if (cfg_lru) ent_used[i] = tick;
          end
        end
      end
      OP_INSERT: begin
        s             = victim_slot();
        ent_valid[s]  = 1'b1;
        ent_page[s]   = it.page_number;
        ent_frame[s]  = it.frame_number;
        ent_loaded[s] = tick;
        ent_used[s]   = tick;
      end
      OP_FLUSH: clear_tlb_model();
      default: ;
    endcase
    tick = tick + 1'b1;
    return r;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic [1:0] op, input logic [PAGE_BITS-1:0] page,
                           input logic [FRAME_BITS-1:0] frame);
    in_item_t it;
    int       gap;
    it.opcode       = op;
    it.page_number  = page;
    it.frame_number = frame;
    gap = draw_wait(in_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    expected_xlat.push_back(translate_item(it));
  endtask

  // drop valid and let the block drain before touching registers
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_xlat.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_POLICY) cfg_lru = val[0];
    else cfg_entries = val[EIU_BITS-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic lru, input logic [EIU_BITS-1:0] n);
    apb_write(REG_POLICY, {31'd0, lru});
    apb_write(REG_ENTRIES, {{(32 - EIU_BITS){1'b0}}, n});
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_basic_ops();
    send_item(OP_LOOKUP, '0, '0);          // empty TLB misses
    send_item(OP_LOOKUP, '1, '1);
    send_item(OP_INSERT, '0, '1);
    send_item(OP_INSERT, '1, '0);
    send_item(OP_INSERT, '1, 20'h12345);   // duplicate page lands in a second entry
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_LOOKUP, '1, '0);          // lowest-indexed copy wins
    send_item(OP_LOOKUP, 20'h55555, '1);
    send_item(OP_UNUSED, '1, '1);          // no-op, tick still advances
    send_item(OP_FLUSH, '1, '1);
    send_item(OP_LOOKUP, '0, '0);
    settle();
  endtask

  task automatic test_fifo_victim();
    configure(POL_FIFO, 5'd2);
    send_item(OP_INSERT, 20'hAAAAA, 20'h00001);
    send_item(OP_INSERT, 20'h0F0F0, 20'h00002);
    send_item(OP_LOOKUP, 20'hAAAAA, '0);   // use does not protect in FIFO mode
    send_item(OP_INSERT, 20'h33333, 20'h00003);
    send_item(OP_LOOKUP, 20'hAAAAA, '0);
    send_item(OP_LOOKUP, 20'h0F0F0, '0);
    settle();
  endtask

  task automatic test_lru_victim();
    configure(POL_LRU, 5'd2);
    send_item(OP_FLUSH, '0, '0);
    send_item(OP_INSERT, 20'h11111, 20'hFFFFE);
    send_item(OP_INSERT, 20'h22222, 20'h7FFFF);
    send_item(OP_LOOKUP, 20'h11111, '0);   // refresh, so the other one goes
    send_item(OP_INSERT, 20'h44444, 20'h80000);
    send_item(OP_LOOKUP, 20'h22222, '0);
    send_item(OP_LOOKUP, 20'h11111, '0);
    send_item(OP_LOOKUP, 20'h44444, '0);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [PAGE_BITS-1:0]  pool [24];
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
    logic [1:0]            op;
    logic                  lru;
    logic [EIU_BITS-1:0]   n;
    int                    r;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin lru = POL_FIFO; n = 5'd16; end
        1: begin lru = POL_LRU;  n = 5'd16; end
        2: begin lru = POL_FIFO; n = 5'd1;  end
        3: begin lru = POL_LRU;  n = 5'd0;  end   // zero acts as one entry
        4: begin lru = POL_FIFO; n = 5'd31; end   // saturates at the built depth
        5: begin lru = POL_LRU;  n = 5'd17; end
        6: begin lru = POL_FIFO; n = 5'd3;  end
        7: begin lru = POL_LRU;  n = 5'd5;  end
        default: begin
          lru = 1'($urandom_range(0, 1));
          n   = EIU_BITS'($urandom_range(0, 31));
        end
      endcase
      configure(lru, n);
      for (int k = 0; k < 24; k++) pool[k] = PAGE_BITS'($urandom());
      for (int i = 0; i < 110; i++) begin
        if (i % 25 == 0) begin
          in_calm  = ($urandom_range(0, 3) == 0);
          out_calm = ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 99);
        if (r < 55)      op = OP_LOOKUP;
        else if (r < 96) op = OP_INSERT;
        else if (r < 97) op = OP_FLUSH;
        else             op = OP_UNUSED;
        // pages mostly from a pool a bit larger than the active set
        if ($urandom_range(0, 9) == 0) page = PAGE_BITS'($urandom());
        else page = pool[$urandom_range(0, (active_entries() + 4 > 23) ? 23
                                              : active_entries() + 4)];
        frame = FRAME_BITS'($urandom());
        send_item(op, page, frame);
      end
      in_calm  = 1'b0;
      out_calm = 1'b0;
      settle();
    end
  endtask

  // ---------------------------------------------------------------- checking
  function automatic void log_mismatch(input out_item_t want, input out_item_t got,
                                       input bit expected_any);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      if (expected_any)
        $display("%0t: result mismatch: expected hit=%0b frame=%05h, got hit=%0b frame=%05h",
                 $realtime, want.hit, want.frame_out, got.hit, got.frame_out);
      else
        $display("%0t: result with nothing pending: hit=%0b frame=%05h",
                 $realtime, got.hit, got.frame_out);
    end
  endfunction

  initial begin : result_check
    int        stall;
    out_item_t want;
    stall       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= (stall == 0);
      if (stall > 0) stall--;
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_xlat.size() == 0) begin
          log_mismatch('0, out_data_o, 1'b0);
        end else begin
          want = expected_xlat.pop_front();
          if (out_data_o.hit !== want.hit || out_data_o.frame_out !== want.frame_out)
            log_mismatch(want, out_data_o, 1'b1);
        end
        stall = draw_wait(out_calm);
      end
    end
  end

  // any transfer or register access counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tlb_fifo_lru_replacement verification failed");
      $finish;
    end
  end

  initial begin : run
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    clear_tlb_model();
    tick        = '0;
    cfg_lru     = POLICY_RST;
    cfg_entries = ENTRIES_RST;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_fifo_victim();
    test_lru_victim();
    test_random_traffic();

    if (mismatch_cnt == 0 && expected_xlat.size() == 0)
      $display("tlb_fifo_lru_replacement verification clean");
    else
      $display("tlb_fifo_lru_replacement verification failed");
    $finish;
  end

endmodule
